FILE: hw/rtl/ase_pkg.sv
// ----------------------------------------------------------------------------
// ase_pkg
// Shared types, step codes and character helpers for the AIVDM sentence
// armor encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ase_pkg;

  // One unit of work handed from the front part to the back part
  typedef struct packed {
    logic        start;   // open a sentence: emit the prefix first
    logic [7:0]  chan;    // channel letter for the prefix
    logic        grp;     // emit one armored group of four characters
    logic [23:0] bytes;   // group bytes, first byte in the top bits
    logic        close;   // emit the trailer after any group
  } ase_cmd_t;

  localparam int unsigned CmdW = $bits(ase_cmd_t);

  // Character sequencer positions
  localparam int unsigned StepW = 5;
  typedef logic [StepW-1:0] ase_step_t;

  localparam ase_step_t STEP_BANG   = 5'd0;
  localparam ase_step_t STEP_PFXEND = 5'd11;
  localparam ase_step_t STEP_CHAN   = 5'd12;
  localparam ase_step_t STEP_COMMA1 = 5'd13;
  localparam ase_step_t STEP_GRP0   = 5'd14;
  localparam ase_step_t STEP_GRP3   = 5'd17;
  localparam ase_step_t STEP_COMMA2 = 5'd18;
  localparam ase_step_t STEP_ZERO   = 5'd19;
  localparam ase_step_t STEP_STAR   = 5'd20;
  localparam ase_step_t STEP_HEXHI  = 5'd21;
  localparam ase_step_t STEP_HEXLO  = 5'd22;
  localparam ase_step_t STEP_NL     = 5'd23;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  // Fixed prefix text "!AIVDM,1,1,,"
  function automatic logic [7:0] prefix_char(input ase_step_t idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h21; // !
      5'd1:    c = 8'h41; // A
      5'd2:    c = 8'h49; // I
      5'd3:    c = 8'h56; // V
      5'd4:    c = 8'h44; // D
      5'd5:    c = 8'h4D; // M
      5'd6:    c = 8'h2C; // ,
      5'd7:    c = 8'h31; // 1
      5'd8:    c = 8'h2C; // ,
      5'd9:    c = 8'h31; // 1
      5'd10:   c = 8'h2C; // ,
      5'd11:   c = 8'h2C; // ,
      default: c = 8'h2C;
    endcase
    return c;
  endfunction

  // Six-bit value to armored ASCII, skipping the gap after 'W'
  function automatic logic [7:0] armor_char(input logic [5:0] v);
    logic [7:0] c;
    if (v >= 6'd40) c = {2'b00, v} + 8'd56;
    else            c = {2'b00, v} + 8'd48;
    return c;
  endfunction

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
    else             c = 8'h37 + {4'h0, nib};
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ase_front.sv
// ----------------------------------------------------------------------------
// ase_front
// Accepts payload bytes, gathers them into groups of three and issues one
// command per byte that needs characters out.
// ----------------------------------------------------------------------------
`default_nettype none

module ase_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic [7:0]       in_channel_char,
  input  wire logic             in_last_byte,
  input  wire logic             q_full,
  output logic                  q_push,
  output ase_pkg::ase_cmd_t     q_push_data
);
  import ase_pkg::*;

  logic        in_sentence_r, in_sentence_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [1:0]  fill_old;
  logic        accept;
  ase_cmd_t    cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the byte and build its command
  always_comb begin
    fill_old        = in_sentence_r ? fill_r : 2'd0;
    in_sentence_nxt = in_sentence_r;
    fill_nxt        = fill_r;
    hi_nxt          = hi_r;
    lo_nxt          = lo_r;
    cmd.start       = !in_sentence_r;
    cmd.chan        = in_channel_char;
    cmd.grp         = 1'b0;
    cmd.close       = in_last_byte;
    cmd.bytes       = 24'h0;
    if (fill_old == 2'd0) begin
      hi_nxt    = in_data_byte;
      fill_nxt  = 2'd1;
      cmd.bytes = {in_data_byte, 16'h0};
      cmd.grp   = in_last_byte;
    end else if (fill_old == 2'd1) begin
      lo_nxt    = in_data_byte;
      fill_nxt  = 2'd2;
      cmd.bytes = {hi_r, in_data_byte, 8'h0};
      cmd.grp   = in_last_byte;
    end else begin
      fill_nxt  = 2'd0;
      cmd.bytes = {hi_r, lo_r, in_data_byte};
      cmd.grp   = 1'b1;
    end
    if (in_last_byte) begin
      in_sentence_nxt = 1'b0;
      fill_nxt        = 2'd0;
    end else begin
      in_sentence_nxt = 1'b1;
    end
  end

  // Skip bytes that only fill the group
  assign q_push      = accept && (cmd.start || cmd.grp || cmd.close);
  assign q_push_data = cmd;

  // Hold group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      fill_r        <= 2'd0;
    end else if (accept) begin
      in_sentence_r <= in_sentence_nxt;
      fill_r        <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ase_queue.sv
// ----------------------------------------------------------------------------
// ase_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ase_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ase_pkg::ase_cmd_t push_data,
  input  wire logic              pop,
  output ase_pkg::ase_cmd_t      pop_data,
  output logic                   full,
  output logic                   empty
);
  import ase_pkg::*;

  ase_cmd_t    mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ase_back.sv
// ----------------------------------------------------------------------------
// ase_back
// Character sequencer: walks prefix, armored group and trailer of each
// command, one character per unstalled cycle; keeps the running checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ase_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire ase_pkg::ase_cmd_t q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_char,
  output logic                   out_sentence_end
);
  import ase_pkg::*;

  logic        active_r;
  ase_cmd_t    cmd_r;
  ase_step_t   step_r, step_nxt, step_first;
  logic        step_done;
  logic [7:0]  xor_r, xor_nxt;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_end_r;
  logic        out_free, adv, load;
  logic [7:0]  ch;
  logic [4:0]  sext_idx;
  logic [5:0]  sext;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = active_r && out_free;

  // Choose the next position, skipping absent parts
  always_comb begin
    step_done = 1'b0;
    step_nxt  = step_r + 5'd1;
    if (step_r == STEP_COMMA1) begin
      if (cmd_r.grp)        step_nxt = STEP_GRP0;
      else if (cmd_r.close) step_nxt = STEP_COMMA2;
      else                  step_done = 1'b1;
    end else if (step_r == STEP_GRP3) begin
      if (cmd_r.close) step_nxt = STEP_COMMA2;
      else             step_done = 1'b1;
    end else if (step_r >= STEP_NL) begin
      step_done = 1'b1;
    end
  end

  always_comb begin
    if (q_data.start)    step_first = STEP_BANG;
    else if (q_data.grp) step_first = STEP_GRP0;
    else                 step_first = STEP_COMMA2;
  end

  assign load  = !q_empty && (!active_r || (adv && step_done));
  assign q_pop = load;

  // Pick the current character
  always_comb begin
    sext_idx = step_r - STEP_GRP0;
    case (sext_idx[1:0])
      2'd0:    sext = cmd_r.bytes[23:18];
      2'd1:    sext = cmd_r.bytes[17:12];
      2'd2:    sext = cmd_r.bytes[11:6];
      default: sext = cmd_r.bytes[5:0];
    endcase
    if (step_r <= STEP_PFXEND)     ch = prefix_char(step_r);
    else if (step_r == STEP_CHAN)  ch = cmd_r.chan;
    else if (step_r == STEP_COMMA1 || step_r == STEP_COMMA2) ch = CHAR_COMMA;
    else if (step_r <= STEP_GRP3)  ch = armor_char(sext);
    else if (step_r == STEP_ZERO)  ch = CHAR_ZERO;
    else if (step_r == STEP_STAR)  ch = CHAR_STAR;
    else if (step_r == STEP_HEXHI) ch = hex_char(xor_r[7:4]);
    else if (step_r == STEP_HEXLO) ch = hex_char(xor_r[3:0]);
    else                           ch = CHAR_NL;
  end

  // Fold characters between '!' and '*' into the checksum
  always_comb begin
    xor_nxt = xor_r;
    if (step_r == STEP_BANG)      xor_nxt = 8'h00;
    else if (step_r <= STEP_ZERO) xor_nxt = xor_r ^ ch;
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= STEP_BANG;
      xor_r    <= 8'h00;
    end else begin
      if (adv) xor_r <= xor_nxt;
      if (load) begin
        active_r <= 1'b1;
        step_r   <= step_first;
      end else if (adv && step_done) begin
        active_r <= 1'b0;
      end else if (adv) begin
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) cmd_r <= q_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_char_r <= ch;
      out_end_r  <= (step_r == STEP_NL);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_sentence_end = out_end_r;

`ifndef SYNTHESIS
  a_end_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_char_r == CHAR_NL)
    else $error("sentence end on a character other than newline");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> step_r <= STEP_NL)
    else $error("sequencer position out of range");

  a_no_prefix_midsentence: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && !cmd_r.start |-> step_r >= STEP_GRP0)
    else $error("prefix emitted for a command that does not open a sentence");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !active_r || (adv && step_done))
    else $error("command loaded while the previous one is unfinished");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ais_sentence_armor_encoder.sv
// ----------------------------------------------------------------------------
// ais_sentence_armor_encoder
// Turns AIS payload bytes into an NMEA AIVDM sentence, one ASCII character
// per output item, with six-bit armoring and XOR checksum trailer.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                    | flow
//  in_     | input     | data_byte, channel_char, last_byte         | valid/stall
//  out_    | output    | out_char, sentence_end                     | valid/stall
//
//  One character leaves per cycle unless the output stalls: the back sequencer
//  is the limit, with a 14-character prefix, 4 characters per three bytes and a
//  6-character trailer. Input bytes enter one per cycle while the two-entry command
//  queue has room. A stalled output holds the sequencer; the front stalls only on
//  a full queue. Synchronous active-low reset returns every part to idle at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ais_sentence_armor_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [7:0] in_channel_char,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_sentence_end
);
  import ase_pkg::*;

  logic      q_full, q_empty, q_push, q_pop;
  ase_cmd_t  q_push_data, q_pop_data;

  ase_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_channel_char (in_channel_char),
    .in_last_byte    (in_last_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_push_data     (q_push_data)
  );

  ase_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ase_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_sentence_end (out_sentence_end)
  );

endmodule

`default_nettype wire
